/* rtl/capacitive_touch_key_detector_defines.svh */
// Assertion macros for the capacitive touch key detector checker.
// Used by rtl/ctkd_checker.sv; expects aclk and aresetn in scope.
`ifndef CAPACITIVE_TOUCH_KEY_DETECTOR_DEFINES_SVH
`define CAPACITIVE_TOUCH_KEY_DETECTOR_DEFINES_SVH

// Checked only out of reset.
`define CTKD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define CTKD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

/* rtl/ctkd_pkg.sv */
// Shared types, codes and constants of the capacitive touch key detector.
// No dependencies; used by every other file but the defines header.
`default_nettype none

package ctkd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GRP_W      = 3;
    localparam int LOCK_W     = 2;
    localparam int ALU_W      = 20;   // holds ten times a 16-bit baseline
    localparam int M_TDATA_W  = 40;   // 34 bits of fields, padded to bytes
    localparam int S_TDATA_W  = 16;
    localparam int APB_AW     = 4;

    localparam logic [LOCK_W-1:0] LOCK_SCANS = 2'd3;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_REPEAT_MODE = 2'd0;
    localparam logic [1:0] REG_SINGLE_SIZE = 2'd1;
    localparam logic [1:0] REG_REPEAT_SIZE = 2'd2;

    localparam logic [GRP_W-1:0] SINGLE_SIZE_RST = 3'd3;
    localparam logic [GRP_W-1:0] REPEAT_SIZE_RST = 3'd6;

    // s_tuser codes
    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    // m_tuser codes
    localparam logic KIND_CALIB = 1'b0;
    localparam logic KIND_SCAN  = 1'b1;

    typedef struct packed {
        logic             sub;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             borrow;   // a < b on a subtract
    } alu_rsp_t;

    // floor(2n/3) for a 3-bit group size
    function automatic logic [GRP_W-1:0] two_thirds(input logic [GRP_W-1:0] n);
        logic [GRP_W-1:0] r;
        case (n)
            3'd0:    r = 3'd0;
            3'd1:    r = 3'd0;
            3'd2:    r = 3'd1;
            3'd3:    r = 3'd2;
            3'd4:    r = 3'd2;
            3'd5:    r = 3'd3;
            3'd6:    r = 3'd4;
            3'd7:    r = 3'd4;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/capacitive_touch_key_detector.sv */
// Top level of the capacitive touch key detector: sequencer, calibration
// store, scan state and APB registers. Depends on ctkd_pkg and ctkd_alu.
`default_nettype none

// Capacitive pad touch detector. Each s_ beat carries either one charge-time
// sample (s_tuser = 0) or a restart-calibration request (s_tuser = 1). After
// reset or a restart the first CAL_SAMPLES samples calibrate: they are
// insertion-sorted into a small register store and the baseline is the floor
// mean of the middle six (all of them if fewer than six), reported as one
// calibration beat with a fail flag when the baseline is above 32767.
// Afterwards samples are grouped into scans (single or repeat group size);
// each finished scan gives one verdict beat with the group peak and a pressed
// flag, with a three-scan lockout that repeat mode clears. Sorting, summing,
// compares and scalings go through one shared 20-bit add/subtract unit
// stepped by the sequencer; the divide by the sample count is a multiply by a
// constant reciprocal. The block takes one beat at a time and drops s_tready
// while busy.
// Per beat: a restart is handled in ST_IDLE; a calibration sample passes
// ST_INSERT once per entry it is shifted past (at most CAL_SAMPLES - 1) and
// once to store it, and the sample that completes the set goes on through
// ST_SUM over the middle entries, ST_DIV and the hand-over state ST_DONE; a
// scan sample that does not close its group passes ST_SC_5B, ST_SC_VALID and
// ST_SC_PEAK, and one that closes it goes on through ST_SC_3R to ST_SC_LT and
// ST_DONE, which repeats while the m_ register holds a beat not yet taken. A
// finished result moves to the m_ register as soon as that is free, so one
// result may wait there while the next beat is taken. The calibration store
// needs no clearing: entries are written before they are read.
module capacitive_touch_key_detector #(
    parameter int CAL_SAMPLES = 10     // 5 .. 16
) (
    input  wire                               aclk,
    input  wire                               aresetn,
    // input stream
    input  wire                               s_tvalid,
    output logic                              s_tready,
    input  wire  [ctkd_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] sample
    input  wire                               s_tuser,   // [0] req_type
    // result stream
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // [0] calib_fail, [16:1] baseline, [17] pressed, [33:18] group_peak,
    // [39:34] zero
    output logic [ctkd_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,   // [0] result_kind
    // configuration
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [ctkd_pkg::APB_AW-1:0]       paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int IW    = (CAL_SAMPLES > 1) ? $clog2(CAL_SAMPLES) : 1;
    localparam int CNT   = (CAL_SAMPLES >= 6) ? 6 : CAL_SAMPLES;
    localparam int LO    = (CAL_SAMPLES >= 6) ? (CAL_SAMPLES - 6) / 2 : 0;
    localparam int SUMW  = ctkd_pkg::SAMPLE_W + $clog2(CNT);
    localparam int SW    = ctkd_pkg::SAMPLE_W;
    localparam int AW    = ctkd_pkg::ALU_W;
    localparam int GW    = ctkd_pkg::GRP_W;
    localparam int LW    = ctkd_pkg::LOCK_W;

    // floor(x * DIV_RECIP / 2^21) equals floor(x / CNT) for any sum of CNT
    // 16-bit samples (CNT of five or six)
    localparam int DIV_SH  = 21;
    localparam int RECIP_W = 20;
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'((2 ** DIV_SH + CNT - 1) / CNT);
    localparam int PROD_W  = SUMW + RECIP_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INSERT,     // one sorted-insertion step per cycle
        ST_SUM,        // add middle entries
        ST_DIV,        // sum times reciprocal of the count
        ST_SC_5B,      // 5 * baseline
        ST_SC_VALID,   // 4s > 5b
        ST_SC_PEAK,    // running peak, group end check
        ST_SC_3R,      // 3 * rval
        ST_SC_GT,      // 3r > 4b
        ST_SC_10B,     // 10 * baseline
        ST_SC_LT,      // r < 10b, lockout
        ST_DONE        // hand result to the output register
    } state_t;

    // --- configuration registers ---
    logic          repeat_mode_reg;
    logic [GW-1:0] single_size_reg;
    logic [GW-1:0] repeat_size_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repeat_mode_reg <= 1'b0;
            single_size_reg <= ctkd_pkg::SINGLE_SIZE_RST;
            repeat_size_reg <= ctkd_pkg::REPEAT_SIZE_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                ctkd_pkg::REG_REPEAT_MODE: repeat_mode_reg <= pwdata[0];
                ctkd_pkg::REG_SINGLE_SIZE: single_size_reg <= pwdata[GW-1:0];
                ctkd_pkg::REG_REPEAT_SIZE: repeat_size_reg <= pwdata[GW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ctkd_pkg::REG_REPEAT_MODE: prdata = {31'd0, repeat_mode_reg};
            ctkd_pkg::REG_SINGLE_SIZE: prdata = {29'd0, single_size_reg};
            ctkd_pkg::REG_REPEAT_SIZE: prdata = {29'd0, repeat_size_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // --- datapath state ---
    state_t         state_reg;
    logic [SW-1:0]  sample_reg;
    logic [SW-1:0]  store_reg [CAL_SAMPLES];
    logic [IW-1:0]  pos_reg;
    logic [IW-1:0]  calib_count_reg;
    logic [IW-1:0]  sum_idx_reg;
    logic [AW-1:0]  acc_reg;
    logic [SW-1:0]  idle_level_reg;
    logic           calibrated_reg;
    logic [GW-1:0]  group_index_reg;
    logic [SW-1:0]  running_peak_reg;
    logic [GW-1:0]  valid_count_reg;
    logic [LW-1:0]  lockout_reg;
    logic [SW-1:0]  rval_reg;
    logic           gt_reg;
    // pending result
    logic           res_kind_reg;
    logic           res_fail_reg;
    logic           res_pressed_reg;
    logic [SW-1:0]  res_peak_reg;
    // output register
    logic                            m_valid_reg;
    logic [ctkd_pkg::M_TDATA_W-1:0]  m_data_reg;
    logic                            m_user_reg;
    logic                            m_load;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_load   = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // --- shared unit and its operand selection ---
    ctkd_pkg::alu_req_t alu_req;
    ctkd_pkg::alu_rsp_t alu_rsp;

    ctkd_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    logic [IW-1:0]     rd_idx;
    logic [SW-1:0]     rd_data;
    logic [GW-1:0]     n_sel;
    logic [GW-1:0]     n_eff;
    logic [GW:0]       idx_inc;
    logic [SW-1:0]     peak_new;
    logic [PROD_W-1:0] quot_prod;
    logic [SW-1:0]     quot;
    logic              hit;
    logic [LW-1:0]     lock_a;
    logic [LW-1:0]     lock_b;

    assign rd_idx   = (state_reg == ST_INSERT)
                    ? ((pos_reg == '0) ? '0 : pos_reg - 1'b1)
                    : sum_idx_reg;
    assign rd_data  = store_reg[rd_idx];

    assign n_sel    = repeat_mode_reg ? repeat_size_reg : single_size_reg;
    assign n_eff    = (n_sel == '0) ? GW'(1) : n_sel;
    assign idx_inc  = {1'b0, group_index_reg} + 1'b1;
    assign peak_new = alu_rsp.borrow ? sample_reg : running_peak_reg;

    // mean of the middle entries
    assign quot_prod = PROD_W'(acc_reg[SUMW-1:0]) * PROD_W'(DIV_RECIP);
    assign quot      = quot_prod[DIV_SH +: SW];

    // lockout update at the end of a scan
    assign hit    = gt_reg & alu_rsp.borrow;
    assign lock_a = repeat_mode_reg ? '0 : lockout_reg;
    assign lock_b = hit ? ctkd_pkg::LOCK_SCANS : lock_a;

    always_comb begin
        alu_req = '0;
        case (state_reg)
            ST_INSERT: begin
                alu_req.sub = 1'b1;
                alu_req.a   = AW'(sample_reg);
                alu_req.b   = AW'(rd_data);
            end
            ST_SUM: begin
                alu_req.a = acc_reg;
                alu_req.b = AW'(rd_data);
            end
            ST_SC_5B: begin
                alu_req.a = AW'({idle_level_reg, 2'b00});
                alu_req.b = AW'(idle_level_reg);
            end
            ST_SC_VALID: begin
                alu_req.sub = 1'b1;
                alu_req.a   = acc_reg;
                alu_req.b   = AW'({sample_reg, 2'b00});
            end
            ST_SC_PEAK: begin
                alu_req.sub = 1'b1;
                alu_req.a   = AW'(running_peak_reg);
                alu_req.b   = AW'(sample_reg);
            end
            ST_SC_3R: begin
                alu_req.a = AW'({rval_reg, 1'b0});
                alu_req.b = AW'(rval_reg);
            end
            ST_SC_GT: begin
                alu_req.sub = 1'b1;
                alu_req.a   = AW'({idle_level_reg, 2'b00});
                alu_req.b   = acc_reg;
            end
            ST_SC_10B: begin
                alu_req.a = AW'({idle_level_reg, 3'b000});
                alu_req.b = AW'({idle_level_reg, 1'b0});
            end
            ST_SC_LT: begin
                alu_req.sub = 1'b1;
                alu_req.a   = AW'(rval_reg);
                alu_req.b   = acc_reg;
            end
            default: alu_req = '0;
        endcase
    end

    // --- sequencer ---
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            calib_count_reg  <= '0;
            idle_level_reg   <= '0;
            calibrated_reg   <= 1'b0;
            group_index_reg  <= '0;
            running_peak_reg <= '0;
            valid_count_reg  <= '0;
            lockout_reg      <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == ctkd_pkg::REQ_RESTART) begin
                            calib_count_reg  <= '0;
                            calibrated_reg   <= 1'b0;
                            group_index_reg  <= '0;
                            running_peak_reg <= '0;
                            valid_count_reg  <= '0;
                            lockout_reg      <= '0;
                        end else begin
                            sample_reg <= s_tdata[SW-1:0];
                            pos_reg    <= calib_count_reg;
                            state_reg  <= calibrated_reg ? ST_SC_5B : ST_INSERT;
                        end
                    end
                end

                ST_INSERT: begin
                    if (pos_reg != '0 && alu_rsp.borrow) begin
                        store_reg[pos_reg] <= rd_data;
                        pos_reg            <= pos_reg - 1'b1;
                    end else begin
                        store_reg[pos_reg] <= sample_reg;
                        if (calib_count_reg == IW'(CAL_SAMPLES - 1)) begin
                            calib_count_reg <= '0;
                            acc_reg         <= '0;
                            sum_idx_reg     <= IW'(LO);
                            state_reg       <= ST_SUM;
                        end else begin
                            calib_count_reg <= calib_count_reg + 1'b1;
                            state_reg       <= ST_IDLE;
                        end
                    end
                end

                ST_SUM: begin
                    acc_reg <= alu_rsp.res;
                    if (sum_idx_reg == IW'(LO + CNT - 1)) begin
                        state_reg <= ST_DIV;
                    end else begin
                        sum_idx_reg <= sum_idx_reg + 1'b1;
                    end
                end

                ST_DIV: begin
                    idle_level_reg   <= quot;
                    calibrated_reg   <= 1'b1;
                    group_index_reg  <= '0;
                    running_peak_reg <= '0;
                    valid_count_reg  <= '0;
                    res_kind_reg     <= ctkd_pkg::KIND_CALIB;
                    res_fail_reg     <= quot[SW-1];   // above 32767
                    res_pressed_reg  <= 1'b0;
                    res_peak_reg     <= '0;
                    state_reg        <= ST_DONE;
                end

                ST_SC_5B: begin
                    acc_reg   <= alu_rsp.res;
                    state_reg <= ST_SC_VALID;
                end

                ST_SC_VALID: begin
                    if (alu_rsp.borrow) begin
                        valid_count_reg <= valid_count_reg + 1'b1;
                    end
                    state_reg <= ST_SC_PEAK;
                end

                ST_SC_PEAK: begin
                    if (idx_inc < {1'b0, n_eff}) begin
                        running_peak_reg <= peak_new;
                        group_index_reg  <= idx_inc[GW-1:0];
                        state_reg        <= ST_IDLE;
                    end else begin
                        rval_reg <= (valid_count_reg >= ctkd_pkg::two_thirds(n_eff))
                                  ? peak_new : '0;
                        state_reg <= ST_SC_3R;
                    end
                end

                ST_SC_3R: begin
                    acc_reg   <= alu_rsp.res;
                    state_reg <= ST_SC_GT;
                end

                ST_SC_GT: begin
                    gt_reg    <= alu_rsp.borrow;
                    state_reg <= ST_SC_10B;
                end

                ST_SC_10B: begin
                    acc_reg   <= alu_rsp.res;
                    state_reg <= ST_SC_LT;
                end

                ST_SC_LT: begin
                    lockout_reg      <= (lock_b != '0) ? lock_b - 1'b1 : '0;
                    group_index_reg  <= '0;
                    running_peak_reg <= '0;
                    valid_count_reg  <= '0;
                    res_kind_reg     <= ctkd_pkg::KIND_SCAN;
                    res_fail_reg     <= 1'b0;
                    res_pressed_reg  <= hit & (lock_a == '0);
                    res_peak_reg     <= rval_reg;
                    state_reg        <= ST_DONE;
                end

                ST_DONE: begin
                    if (m_load) begin
                        m_user_reg  <= res_kind_reg;
                        m_data_reg  <= {{(ctkd_pkg::M_TDATA_W - 2 * SW - 2){1'b0}},
                                        res_peak_reg, res_pressed_reg,
                                        idle_level_reg, res_fail_reg};
                        state_reg   <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* rtl/ctkd_alu.sv */
// Shared add/subtract unit of the capacitive touch key detector.
// Depends on ctkd_pkg for the request and response structs.
`default_nettype none

module ctkd_alu (
    input  ctkd_pkg::alu_req_t req,
    output ctkd_pkg::alu_rsp_t rsp
);

    logic [ctkd_pkg::ALU_W:0] sum;
    logic [ctkd_pkg::ALU_W-1:0] b_op;

    assign b_op = req.sub ? ~req.b : req.b;
    assign sum  = {1'b0, req.a} + {1'b0, b_op}
                + {{ctkd_pkg::ALU_W{1'b0}}, req.sub};

    assign rsp.res    = sum[ctkd_pkg::ALU_W-1:0];
    assign rsp.borrow = req.sub & ~sum[ctkd_pkg::ALU_W];

endmodule

`default_nettype wire

/* rtl/ctkd_checker.sv */
// Port-level checker of the capacitive touch key detector and its bind.
// Depends on ctkd_pkg and capacitive_touch_key_detector_defines.svh.
`default_nettype none

`include "capacitive_touch_key_detector_defines.svh"

module ctkd_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        s_tuser,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [39:0] m_tdata,
    input wire        m_tuser
);

    // stalled result beat holds
    `CTKD_ASSERT(a_m_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "m_ beat changed under stall")

    // s_tready is always low in the cycle after a sample beat is taken
    `CTKD_ASSERT(a_busy_after_sample, s_tvalid && s_tready && s_tuser == ctkd_pkg::REQ_SAMPLE |=> !s_tready, "ready straight after a sample beat")

    // calibration beat carries no press and no peak
    `CTKD_ASSERT(a_calib_fields, m_tvalid && m_tuser == ctkd_pkg::KIND_CALIB |-> m_tdata[17] == 1'b0 && m_tdata[33:18] == 16'd0, "calibration beat with scan fields")

    // a press needs a peak above 4/3 of the baseline, so never zero
    `CTKD_ASSERT(a_press_peak, m_tvalid && m_tuser == ctkd_pkg::KIND_SCAN && m_tdata[17] |-> m_tdata[33:18] != 16'd0 && m_tdata[0] == 1'b0, "press with zero peak or fail flag")

    `CTKD_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_tvalid, "m_tvalid after reset")

endmodule

bind capacitive_touch_key_detector ctkd_checker u_ctkd_checker (.*);

`default_nettype wire

/* dv/capacitive_touch_key_detector_test.sv */
// Self-checking testbench for the capacitive touch key detector.
// Needs ctkd_pkg and the capacitive_touch_key_detector RTL; reads no files.
`default_nettype none

module capacitive_touch_key_detector_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ctkd_pkg::*;

    localparam int CAL_N          = 10;        // calibration samples per run
    localparam int BASE_FAIL_MAX  = 32767;     // highest baseline that passes
    localparam int ITEM_TARGET    = 1950;
    localparam int SETTLE_CYCLES  = 64;
    localparam int CYCLE_LIMIT    = 1_000_000;

    // One result beat, as the checker sees it.
    typedef struct packed {
        logic        kind;
        logic        fail;
        logic [15:0] base;
        logic        press;
        logic [15:0] peak;
    } touch_report_t;

    // One directed stimulus beat; typed rows carry their own expectation.
    typedef struct packed {
        logic          req;
        logic [15:0]   smp;
        bit            typed;
        bit            yields;
        touch_report_t rep;
    } stim_row_t;

    typedef enum int {RUN_IDLE, RUN_TOUCH, RUN_NOISE} run_kind_t;

    localparam touch_report_t NO_REPORT = '{KIND_CALIB, 1'b0, 16'h0000, 1'b0, 16'h0000};

    // Directed part: saturated calibration (fails), a scan against that baseline
    // where nothing can pass, a restart, then a calibration whose middle six are
    // zero, and one scan group against a zero baseline.
    localparam stim_row_t DIRECTED [27] = '{
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b1,
          '{KIND_CALIB, 1'b1, 16'hFFFF, 1'b0, 16'h0000}},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h8000, 1'b1, 1'b1,
          '{KIND_SCAN, 1'b0, 16'hFFFF, 1'b0, 16'h0000}},
        '{REQ_RESTART, 16'h5A5A, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b1, 1'b1,
          '{KIND_CALIB, 1'b0, 16'h0000, 1'b0, 16'h0000}},
        '{REQ_SAMPLE,  16'h0001, 1'b0, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'hFFFF, 1'b0, 1'b0, NO_REPORT},
        '{REQ_SAMPLE,  16'h0000, 1'b0, 1'b0, NO_REPORT}
    };

    // ---------------------------------------------------------------- DUT ports
    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;    // [15:0] sample
    logic                  s_tuser;    // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready;
    // [0] calib_fail, [16:1] baseline, [17] pressed, [33:18] group_peak
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tuser;    // [0] result_kind
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    capacitive_touch_key_detector #(.CAL_SAMPLES(CAL_N)) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------- detector state mirror
    logic [15:0]   cal_store [CAL_N];
    int            cal_count;
    logic [15:0]   idle_lvl;
    bit            calibrated;
    int            grp_idx;
    logic [15:0]   run_peak;
    int            pass_count;
    int            lock_left;
    bit            cfg_repeat;
    int            cfg_single_size;
    int            cfg_repeat_size;

    touch_report_t pending_reports [$];   // verdicts still owed by the block
    int            mismatches;
    int            items_sent;
    int            cycle_count;
    int            send_calm;             // beats left in a no-idle stretch
    int            sink_calm;

    // Work out what one accepted beat makes the detector report, if anything.
    function automatic bit predict_touch(input logic req, input logic [15:0] smp,
                                         output touch_report_t rep);
        int pos;
        int lo;
        int cnt;
        int sum;
        int base;
        int n;
        int peak_out;
        rep = NO_REPORT;
        if (req == REQ_RESTART) begin
            cal_count  = 0;
            calibrated = 1'b0;
            grp_idx    = 0;
            run_peak   = '0;
            pass_count = 0;
            lock_left  = 0;
            return 1'b0;
        end
        if (!calibrated) begin
            // insertion sort into the calibration store
            pos = cal_count;
            while (pos > 0 && cal_store[pos-1] > smp) begin
                cal_store[pos] = cal_store[pos-1];
                pos--;
            end
            cal_store[pos] = smp;
            cal_count++;
            if (cal_count < CAL_N)
                return 1'b0;
            cnt = (CAL_N >= 6) ? 6 : CAL_N;
            lo  = (CAL_N >= 6) ? (CAL_N - 6) / 2 : 0;
            sum = 0;
            for (int i = 0; i < cnt; i++)
                sum += int'(cal_store[lo + i]);
            idle_lvl   = 16'(sum / cnt);
            cal_count  = 0;
            calibrated = 1'b1;
            grp_idx    = 0;
            run_peak   = '0;
            pass_count = 0;
            rep.kind   = KIND_CALIB;
            rep.fail   = (int'(idle_lvl) > BASE_FAIL_MAX);
            rep.base   = idle_lvl;
            return 1'b1;
        end
        base = int'(idle_lvl);
        n    = cfg_repeat ? cfg_repeat_size : cfg_single_size;
        if (n == 0)
            n = 1;
        if (int'(smp) > base * 5 / 4)
            pass_count++;
        if (smp > run_peak)
            run_peak = smp;
        grp_idx++;
        if (grp_idx < n)
            return 1'b0;
        peak_out = (pass_count >= n * 2 / 3) ? int'(run_peak) : 0;
        if (cfg_repeat)
            lock_left = 0;
        rep.press = 1'b0;
        if (peak_out > base * 4 / 3 && peak_out < base * 10) begin
            if (lock_left == 0)
                rep.press = 1'b1;
            lock_left = int'(LOCK_SCANS);
        end
        if (lock_left != 0)
            lock_left--;
        grp_idx    = 0;
        run_peak   = '0;
        pass_count = 0;
        rep.kind   = KIND_SCAN;
        rep.fail   = 1'b0;
        rep.base   = idle_lvl;
        rep.peak   = 16'(peak_out);
        return 1'b1;
    endfunction

    // Per-beat wait in cycles, with the odd stretch of back-to-back beats.
    function automatic int draw_wait(inout int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 30) == 0) begin
            calm = $urandom_range(8, 60);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic logic [15:0] sat16(input int v);
        if (v < 0)
            return 16'h0000;
        return (v > 65535) ? 16'hFFFF : 16'(v);
    endfunction

    function automatic logic [2:0] pick_size();
        case ($urandom_range(0, 5))
            0:       return 3'd0;
            1:       return 3'd7;
            2:       return 3'd1;
            default: return 3'($urandom_range(0, 7));
        endcase
    endfunction

    // Send one beat on the s_ side. We enter and leave on a rising edge; valid
    // is only dropped when a gap is actually taken, so back-to-back beats keep
    // it high.
    task automatic drive_beat(input logic req, input logic [15:0] smp, input bit typed,
                              input bit yields, input touch_report_t fixed);
        int            gap;
        bit            hit;
        touch_report_t rep;
        gap = draw_wait(send_calm);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        // mirror always advances; typed rows override what it says
        hit = predict_touch(req, smp, rep);
        if (typed) begin
            if (yields)
                pending_reports.push_back(fixed);
        end else if (hit) begin
            pending_reports.push_back(rep);
        end
    endtask

    // Quiesce: no beat offered, every verdict collected, then let any
    // no-result work (e.g. a restart in flight) drain before touching registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Three back-to-back APB writes; psel stays up across them so it is never
    // dropped and raised on the same edge.
    task automatic program_settings(input logic mode, input logic [2:0] single_sz,
                                    input logic [2:0] repeat_sz);
        logic [1:0] idx;
        logic [2:0] val;
        for (int r = 0; r < 3; r++) begin
            case (r)
                0:       begin idx = REG_REPEAT_MODE; val = {2'b00, mode}; end
                1:       begin idx = REG_SINGLE_SIZE; val = single_sz; end
                default: begin idx = REG_REPEAT_SIZE; val = repeat_sz; end
            endcase
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {idx, 2'b00};
            pwdata  <= 32'(val);
            @(posedge aclk);
            penable <= 1'b1;
            do @(posedge aclk); while (!pready);
            case (idx)
                REG_REPEAT_MODE: cfg_repeat      = val[0];
                REG_SINGLE_SIZE: cfg_single_size = int'(val);
                default:         cfg_repeat_size = int'(val);
            endcase
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------ stimulus
    initial begin
        int            level;
        int            chunk;
        int            abort_at;
        int            run_left;
        int            base;
        run_kind_t     run_kind;
        logic [15:0]   smp;
        // mirror comes up in its reset state
        cal_count       = 0;
        idle_lvl        = '0;
        calibrated      = 1'b0;
        grp_idx         = 0;
        run_peak        = '0;
        pass_count      = 0;
        lock_left       = 0;
        cfg_repeat      = 1'b0;
        cfg_single_size = int'(SINGLE_SIZE_RST);
        cfg_repeat_size = int'(REPEAT_SIZE_RST);
        mismatches      = 0;
        items_sent      = 0;
        send_calm       = 0;
        run_left        = 0;
        run_kind        = RUN_IDLE;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= REQ_SAMPLE;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, default register settings
        foreach (DIRECTED[r])
            drive_beat(DIRECTED[r].req, DIRECTED[r].smp, DIRECTED[r].typed,
                       DIRECTED[r].yields, DIRECTED[r].rep);

        // random phases: each one reprograms the block, usually recalibrates,
        // then streams scan samples shaped around the current baseline
        for (int phase = 0; items_sent < ITEM_TARGET; phase++) begin
            settle();
            program_settings(1'($urandom_range(0, 1)), pick_size(), pick_size());

            // now and then keep the old baseline and any half-filled group
            if (phase > 0 && $urandom_range(0, 4) != 0) begin
                drive_beat(REQ_RESTART, 16'($urandom), 1'b0, 1'b0, NO_REPORT);
                case ($urandom_range(0, 9))
                    0:       level = $urandom_range(BASE_FAIL_MAX + 1, 65535);
                    1:       level = $urandom_range(0, 15);
                    default: level = $urandom_range(16, 30000);
                endcase
                // calibration abandoned part-way by a second restart
                abort_at = ($urandom_range(0, 3) == 0) ? $urandom_range(1, CAL_N - 1) : 0;
                for (int c = 0; c < CAL_N + abort_at; c++) begin
                    if (abort_at != 0 && c == abort_at) begin
                        drive_beat(REQ_RESTART, 16'($urandom), 1'b0, 1'b0, NO_REPORT);
                    end else begin
                        // jitter around the idle level, odd outlier for the trim
                        if ($urandom_range(0, 7) == 0)
                            smp = 16'($urandom);
                        else
                            smp = sat16(level + int'($urandom_range(0, level / 8 + 2))
                                        - level / 16);
                        drive_beat(REQ_SAMPLE, smp, 1'b0, 1'b0, NO_REPORT);
                    end
                end
            end

            chunk = $urandom_range(40, 120);
            for (int k = 0; k < chunk; k++) begin
                if ($urandom_range(0, 199) == 0) begin
                    drive_beat(REQ_RESTART, 16'($urandom), 1'b0, 1'b0, NO_REPORT);
                end else begin
                    if (run_left == 0) begin
                        case ($urandom_range(0, 9))
                            0, 1:          run_kind = RUN_NOISE;
                            2, 3, 4, 5:    run_kind = RUN_TOUCH;
                            default:       run_kind = RUN_IDLE;
                        endcase
                        run_left = $urandom_range(1, 8);
                    end
                    run_left--;
                    base = int'(idle_lvl);
                    case (run_kind)
                        RUN_NOISE: smp = 16'($urandom);
                        RUN_TOUCH: smp = sat16(base + base / 2
                                               + int'($urandom_range(0, base)));
                        default:   smp = sat16(base + int'($urandom_range(0, base / 4 + 2))
                                               - base / 8 - 1);
                    endcase
                    drive_beat(REQ_SAMPLE, smp, 1'b0, 1'b0, NO_REPORT);
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------ result checking
    initial begin
        touch_report_t want;
        int            gap;
        sink_calm = 0;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            gap = draw_wait(sink_calm);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            // beat taken at this edge
            if (pending_reports.size() == 0) begin
                $error("result beat with nothing expected: kind %0d, tdata %h",
                       m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = pending_reports.pop_front();
                check_field("result_kind", int'(want.kind),  int'(m_tuser));
                check_field("calib_fail",  int'(want.fail),  int'(m_tdata[0]));
                check_field("baseline",    int'(want.base),  int'(m_tdata[16:1]));
                check_field("pressed",     int'(want.press), int'(m_tdata[17]));
                check_field("group_peak",  int'(want.peak),  int'(m_tdata[33:18]));
            end
        end
    end

    // hang guard
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

`default_nettype wire
